/* design/ipv4_tcp_payload_string_filter_macros.svh */
// assertion macros for the ipv4 tcp payload string filter checker
// no dependencies; included by the checker file only
`ifndef IPV4_TCP_PAYLOAD_STRING_FILTER_MACROS_SVH
`define IPV4_TCP_PAYLOAD_STRING_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ITPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ITPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/itpf_pkg.sv */
// shared types and constants of the ipv4 tcp payload string filter
// no dependencies
package itpf_pkg;

	// bytes held by the three pattern registers
	localparam int PatRegBytes = 24;

	localparam logic [1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [1:0] CFG_PAT_MID  = 2'd1;
	localparam logic [1:0] CFG_PAT_HIGH = 2'd2;
	localparam logic [1:0] CFG_PAT_LEN  = 2'd3;

	localparam logic [2:0] CLS_NOT_IPV4    = 3'd0;
	localparam logic [2:0] CLS_BAD_IP_LEN  = 3'd1;
	localparam logic [2:0] CLS_NOT_TCP     = 3'd2;
	localparam logic [2:0] CLS_BAD_TCP_LEN = 3'd3;
	localparam logic [2:0] CLS_NO_PAYLOAD  = 3'd4;
	localparam logic [2:0] CLS_SEARCHED    = 3'd5;

	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [15:0] PROTO_POS   = 16'd9;
	localparam logic [15:0] TCP_OFFS_POS = 16'd12;
	localparam logic [5:0] HDR_MIN      = 6'd20;
	localparam logic [5:0] HDR_MAX      = 6'd60;

	typedef enum logic [2:0] {
		PROG_START,
		PROG_IP_HDR,
		PROG_TCP_HDR,
		PROG_PAYLOAD,
		PROG_REJ_VERSION,
		PROG_REJ_IP_LEN,
		PROG_REJ_PROTO,
		PROG_REJ_TCP_LEN
	} prog_t;

	// one classified byte handed from the parser to the matcher
	typedef struct packed {
		logic [7:0] data;
		logic       feed;
		logic       last;
		logic [2:0] cls;
	} entry_t;

	typedef struct packed {
		logic       drop;
		logic [2:0] cls;
	} result_t;

	function automatic logic hdr_len_ok(input logic [5:0] h);
		return (h >= HDR_MIN) && (h <= HDR_MAX);
	endfunction

endpackage

/* design/itpf_fifo.sv */
// small register queue used between the filter stages
// no dependencies
module itpf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_A) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_A) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/itpf_front.sv */
// header parser: tracks byte position and parse state, tags payload bytes
// depends on itpf_pkg
module itpf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      packet_byte,
	input  logic            last_byte,
	output itpf_pkg::entry_t entry
);
	import itpf_pkg::*;

	prog_t       prog_q, prog_d;
	logic [15:0] pos_q;
	logic [5:0]  ihl_q, ihl_d;
	logic [6:0]  pst_q, pst_d;
	logic [5:0]  hlen;
	logic [16:0] count;
	logic        feed;
	logic [2:0]  cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= PROG_START;
			pos_q  <= '0;
			ihl_q  <= '0;
			pst_q  <= '0;
		end else if (take) begin
			if (last_byte) begin
				prog_q <= PROG_START;
				pos_q  <= '0;
				ihl_q  <= '0;
				pst_q  <= '0;
			end else begin
				prog_q <= prog_d;
				ihl_q  <= ihl_d;
				pst_q  <= pst_d;
				if (pos_q != 16'hffff) begin
					pos_q <= pos_q + 16'd1;
				end
			end
		end
	end

	always_comb begin
		prog_d = prog_q;
		ihl_d  = ihl_q;
		pst_d  = pst_q;
		hlen   = '0;
		feed   = 1'b0;
		unique case (prog_q)
			PROG_START: begin
				hlen = {packet_byte[3:0], 2'b00};
				if (packet_byte[7:4] != IP_VERSION_4) begin
					prog_d = PROG_REJ_VERSION;
				end else if (!hdr_len_ok(hlen)) begin
					prog_d = PROG_REJ_IP_LEN;
				end else begin
					ihl_d  = hlen;
					prog_d = PROG_IP_HDR;
				end
			end
			PROG_IP_HDR: begin
				if (pos_q == PROTO_POS) begin
					prog_d = (packet_byte == PROTO_TCP) ? PROG_TCP_HDR : PROG_REJ_PROTO;
				end
			end
			PROG_TCP_HDR: begin
				hlen = {packet_byte[7:4], 2'b00};
				if (pos_q == 16'(ihl_q) + TCP_OFFS_POS) begin
					if (!hdr_len_ok(hlen)) begin
						prog_d = PROG_REJ_TCP_LEN;
					end else begin
						pst_d  = 7'(ihl_q) + 7'(hlen);
						prog_d = PROG_PAYLOAD;
					end
				end
			end
			PROG_PAYLOAD: begin
				feed = (pos_q >= 16'(pst_q));
			end
			default: begin
			end
		endcase
	end

	// class as seen after this byte, used only on the last one
	assign count = 17'(pos_q) + 17'd1;

	always_comb begin
		case (prog_d)
			PROG_REJ_VERSION: cls = CLS_NOT_IPV4;
			PROG_REJ_IP_LEN:  cls = CLS_BAD_IP_LEN;
			PROG_REJ_PROTO:   cls = CLS_NOT_TCP;
			PROG_REJ_TCP_LEN: cls = CLS_BAD_TCP_LEN;
			PROG_PAYLOAD: begin
				if (count < 17'(pst_d)) begin
					cls = CLS_NOT_IPV4;
				end else if (count == 17'(pst_d)) begin
					cls = CLS_NO_PAYLOAD;
				end else begin
					cls = CLS_SEARCHED;
				end
			end
			default: cls = CLS_NOT_IPV4;
		endcase
	end

	always_comb begin
		entry.data = packet_byte;
		entry.feed = feed;
		entry.last = last_byte;
		entry.cls  = cls;
	end

endmodule

/* design/itpf_back.sv */
// payload matcher: sliding window compare against the right-aligned pattern
// depends on itpf_pkg
module itpf_back #(
	parameter int MAX_PATTERN = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [63:0]      pat_low,
	input  logic [63:0]      pat_mid,
	input  logic [63:0]      pat_high,
	input  logic [4:0]       pat_len,
	input  logic             in_valid,
	input  itpf_pkg::entry_t in_entry,
	output logic             in_take,
	input  logic             out_full,
	output logic             out_push,
	output itpf_pkg::result_t out_result
);
	import itpf_pkg::*;

	localparam int CAP = (MAX_PATTERN < PatRegBytes) ? MAX_PATTERN : PatRegBytes;
	localparam int FW  = $clog2(CAP + 1);
	localparam logic [4:0]    CAP_L  = 5'(CAP);
	localparam logic [FW-1:0] CAP_F  = FW'(CAP);

	logic [7:0]      pat_bytes [PatRegBytes];
	logic [191:0]    pat_all;
	logic [4:0]      n_len;
	logic [7:0]      pat_al_q [CAP];
	logic [7:0]      pat_al_d [CAP];
	logic [CAP-1:0]  mask_q, mask_d;
	logic [4:0]      n_q;
	logic [7:0]      win_q  [CAP];
	logic [7:0]      win_nx [CAP];
	logic [FW-1:0]   fill_q, fill_nx;
	logic            match_q;
	logic [CAP-1:0]  eq;
	logic            hit;

	assign pat_all = {pat_high, pat_mid, pat_low};
	assign n_len   = (pat_len > CAP_L) ? CAP_L : pat_len;

	// pattern byte k right-aligned so its last byte meets the newest window slot
	always_comb begin
		int idx;
		for (int k = 0; k < PatRegBytes; k++) begin
			pat_bytes[k] = pat_all[8*k +: 8];
		end
		for (int j = 0; j < CAP; j++) begin
			idx = j + int'(n_len) - CAP;
			if (idx >= 0) begin
				mask_d[j]   = 1'b1;
				pat_al_d[j] = pat_bytes[idx[4:0]];
			end else begin
				mask_d[j]   = 1'b0;
				pat_al_d[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			n_q    <= '0;
			for (int j = 0; j < CAP; j++) begin
				pat_al_q[j] <= '0;
			end
		end else begin
			mask_q <= mask_d;
			n_q    <= n_len;
			for (int j = 0; j < CAP; j++) begin
				pat_al_q[j] <= pat_al_d[j];
			end
		end
	end

	assign in_take = in_valid && !out_full;

	always_comb begin
		for (int j = 0; j < CAP - 1; j++) begin
			win_nx[j] = win_q[j+1];
		end
		win_nx[CAP-1] = in_entry.data;
		fill_nx = (fill_q < CAP_F) ? fill_q + FW'(1) : fill_q;
		for (int j = 0; j < CAP; j++) begin
			eq[j] = !mask_q[j] || (win_nx[j] == pat_al_q[j]);
		end
		hit = in_entry.feed && (n_q != '0) && (6'(fill_nx) >= 6'(n_q)) && (&eq);
	end

	always_ff @(posedge clk) begin
		if (in_take && in_entry.feed) begin
			for (int j = 0; j < CAP; j++) begin
				win_q[j] <= win_nx[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			match_q <= 1'b0;
		end else if (in_take) begin
			if (in_entry.last) begin
				fill_q  <= '0;
				match_q <= 1'b0;
			end else if (in_entry.feed) begin
				fill_q <= fill_nx;
				if (hit) begin
					match_q <= 1'b1;
				end
			end
		end
	end

	assign out_push        = in_take && in_entry.last;
	assign out_result.cls  = in_entry.cls;
	assign out_result.drop = (in_entry.cls == CLS_SEARCHED) && (match_q || hit);

endmodule

/* design/ipv4_tcp_payload_string_filter.sv */
// top level of the ipv4 tcp payload string filter
// depends on itpf_pkg, itpf_fifo, itpf_front, itpf_back
//
// takes an ip packet one byte per push, last_byte set on its final byte,
// and returns one item per packet: a drop verdict and a parse class. the
// parser checks version 4, an ip header length of 20..60, protocol tcp and
// a tcp header length of 20..60; every byte past both headers is payload
// and is searched for the configured pattern (pattern_length bytes, up to
// the smaller of 24 and MAX_PATTERN, 0 disables matching). drop is set only
// for class 5 when the pattern was seen. throughput is one byte per clock
// while neither queue is full, set by the combinational parallel window
// compare in the matcher; the result item is registered in the mid queue
// as the last byte's entry and then in the output queue. the parser and
// the matcher are decoupled by a four-entry queue and results leave through
// a two-entry queue, so a stall on either side is absorbed until they fill.
// configuration writes are always ready and should be done with no packet
// in flight.
module ipv4_tcp_payload_string_filter #(
	parameter int MAX_PATTERN = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// packet byte input
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic        push,
	output logic        full,
	// result output
	output logic        drop_verdict,
	output logic [2:0]  parse_class,
	output logic        empty,
	input  logic        pop,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import itpf_pkg::*;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// configuration registers
	logic [63:0] pat_low_q, pat_mid_q, pat_high_q;
	logic [4:0]  pat_len_q;

	// parser to matcher queue
	entry_t  front_entry, mid_entry;
	logic    front_take;
	logic    mid_full, mid_empty, mid_pop;

	// matcher to output queue
	result_t back_result, out_result;
	logic    back_push, out_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_mid_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				CFG_PAT_MID:  pat_mid_q  <= cfg_data;
				CFG_PAT_HIGH: pat_high_q <= cfg_data;
				CFG_PAT_LEN:  pat_len_q  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// a byte is parsed in the cycle it is accepted and lands in the mid queue
	assign full       = mid_full;
	assign front_take = push && !mid_full;

	itpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (front_take),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.entry       (front_entry)
	);

	itpf_fifo #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_take),
		.wr_data (front_entry),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_entry),
		.empty   (mid_empty)
	);

	// matcher only drains when the output queue has room
	itpf_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pat_low    (pat_low_q),
		.pat_mid    (pat_mid_q),
		.pat_high   (pat_high_q),
		.pat_len    (pat_len_q),
		.in_valid   (!mid_empty),
		.in_entry   (mid_entry),
		.in_take    (mid_pop),
		.out_full   (out_full),
		.out_push   (back_push),
		.out_result (back_result)
	);

	itpf_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_push),
		.wr_data (back_result),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_result),
		.empty   (empty)
	);

	assign drop_verdict = out_result.drop;
	assign parse_class  = out_result.cls;

endmodule

/* design/itpf_checker.sv */
// port-level checks of the ipv4 tcp payload string filter, bound to the top
// depends on itpf_pkg and ipv4_tcp_payload_string_filter_macros.svh
`include "ipv4_tcp_payload_string_filter_macros.svh"

module itpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [7:0]  packet_byte,
	input logic        last_byte,
	input logic        push,
	input logic        full,
	input logic        drop_verdict,
	input logic [2:0]  parse_class,
	input logic        empty,
	input logic        pop,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [63:0] cfg_data
);
	import itpf_pkg::*;

	// a waiting result holds until it is taken
	`ITPF_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(drop_verdict) && $stable(parse_class), "waiting result changed before pop")

	// drop only when the payload was actually searched
	`ITPF_ASSERT_NOW(a_drop_needs_search, clk, arst_n, !empty && drop_verdict, parse_class == CLS_SEARCHED, "drop with class other than payload searched")

	// class stays within its defined codes
	`ITPF_ASSERT_NOW(a_class_range, clk, arst_n, !empty, parse_class == CLS_NOT_IPV4 || parse_class == CLS_BAD_IP_LEN || parse_class == CLS_NOT_TCP || parse_class == CLS_BAD_TCP_LEN || parse_class == CLS_NO_PAYLOAD || parse_class == CLS_SEARCHED, "parse class out of range")

endmodule

bind ipv4_tcp_payload_string_filter itpf_checker u_itpf_checker (.*);
